// ===== rtl/tersc_pkg.sv =====
// ----------------------------------------------------------------------------
// tersc_pkg: shared types and constants for the row-scan lane edge finder
// Payload structs of both channels, the stage word between the input
// register and the scan core, and register defaults.
// ----------------------------------------------------------------------------
package tersc_pkg;

   // column and length widths follow from the 256-column cap of the fields
   localparam int COL_W        = 8;
   localparam int LEN_W        = 9;
   localparam int WIDTH_CAP    = 256;
   localparam int DEFAULT_MAX_WIDTH = 256;

   // row_width register
   localparam int               ROW_WIDTH_W     = 9;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 9'd160;

   // input word
   typedef struct packed {
      logic pixel;
      logic first_row;
   } req_payload_type;

   // result word
   typedef struct packed {
      logic [COL_W-1:0] left_edge;
      logic [COL_W-1:0] right_edge;
      logic             edge_found;
      logic [COL_W-1:0] mid_column;
      logic             mid_valid;
   } rsp_payload_type;

   // word held by the input register, seen by the scan core
   typedef struct packed {
      logic            valid;
      req_payload_type data;
   } stage_type;

endpackage

// ===== rtl/tersc_if.sv =====
// ----------------------------------------------------------------------------
// tersc_if: valid/ready channels of the row-scan lane edge finder
// One interface for the pixel channel and one for the result channel.
// ----------------------------------------------------------------------------
interface tersc_req_if import tersc_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface tersc_rsp_if import tersc_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/tersc_in_reg.sv =====
// ----------------------------------------------------------------------------
// tersc_in_reg: input register
// Captures one pixel word; takes a new word whenever it is empty or the
// scan core consumes the held word in the same cycle.
// ----------------------------------------------------------------------------
module tersc_in_reg import tersc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tersc_req_if.sink req_if,
   input  logic      advance,
   output stage_type stage
);

   logic            valid_ff, valid_in;
   req_payload_type data_ff, data_in;
   logic            take;

   // free slot or slot draining this cycle
   assign take          = !valid_ff || advance;
   assign req_if.ready  = take;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (take) begin
         valid_in = req_if.valid;
         if (req_if.valid) begin
            data_in = req_if.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule

// ===== rtl/tersc_core.sv =====
// ----------------------------------------------------------------------------
// tersc_core: run tracking and row-end result register
// Follows white runs along the row, keeps the longest run that overlaps the
// previous row's segment and loads the result register at the row end.
// ----------------------------------------------------------------------------
module tersc_core import tersc_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ROW_WIDTH_W-1:0] row_width,
   input  stage_type              stage,
   output logic                   advance,
   tersc_rsp_if.source            rsp_if
);

   localparam int               CAP   = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
   localparam logic [LEN_W-1:0] CAP_W = LEN_W'(CAP);

   // row state
   logic [COL_W-1:0] column_ff, column_in;
   logic [COL_W-1:0] run_start_ff, run_start_in;
   logic [LEN_W-1:0] run_length_ff, run_length_in;
   logic [COL_W-1:0] best_start_ff, best_start_in;
   logic [COL_W-1:0] best_end_ff, best_end_in;
   logic [LEN_W-1:0] best_length_ff, best_length_in;
   // previous row
   logic [COL_W-1:0] prev_left_ff, prev_left_in;
   logic [COL_W-1:0] prev_right_ff, prev_right_in;
   logic             prev_found_ff, prev_found_in;
   logic [COL_W-1:0] prev_mid_ff, prev_mid_in;
   logic             prev_mid_valid_ff, prev_mid_valid_in;
   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   logic [LEN_W-1:0] eff_width;
   logic [LEN_W-1:0] last_col;
   logic             row_end;
   logic             pixel, first;

   logic [COL_W-1:0] run_start_n;
   logic [LEN_W-1:0] run_length_n;
   logic             judge_en;
   logic [COL_W-1:0] judge_start, judge_end;
   logic [LEN_W-1:0] judge_len;
   logic             overlap, take_run;
   logic [COL_W-1:0] best_start_n, best_end_n;
   logic [LEN_W-1:0] best_length_n;

   logic             found, mvalid;
   logic [COL_W-1:0] left, right, mid;
   logic [COL_W:0]   mid_sum;

   assign pixel = stage.data.pixel;
   assign first = stage.data.first_row;

   // clamp width to 1..cap and find the last column
   always_comb begin
      eff_width = row_width;
      if (eff_width == '0) begin
         eff_width = LEN_W'(1);
      end else if (eff_width > CAP_W) begin
         eff_width = CAP_W;
      end
   end
   assign last_col = eff_width - LEN_W'(1);
   assign row_end  = {1'b0, column_ff} >= last_col;

   // stalls only when a row-end word meets an unaccepted result
   assign advance = stage.valid && (!row_end || !rsp_valid_ff || rsp_if.ready);

   // run update and which run is judged on this pixel
   always_comb begin
      run_start_n  = run_start_ff;
      run_length_n = run_length_ff;
      judge_en     = 1'b0;
      judge_start  = run_start_ff;
      judge_end    = column_ff - COL_W'(1);
      judge_len    = run_length_ff;
      if (pixel) begin
         if (run_length_ff == '0) begin
            run_start_n  = column_ff;
            run_length_n = LEN_W'(1);
         end else if (run_length_ff != '1) begin
            run_length_n = run_length_ff + LEN_W'(1);
         end
         judge_en    = row_end;
         judge_start = run_start_n;
         judge_end   = column_ff;
         judge_len   = run_length_n;
      end else begin
         judge_en     = run_length_ff != '0;
         run_start_n  = '0;
         run_length_n = '0;
      end
   end

   // overlap with previous segment; later run wins a tie
   assign overlap  = prev_found_ff &&
                     !((prev_left_ff > judge_end) || (prev_right_ff < judge_start));
   assign take_run = judge_en && (first || overlap) && (judge_len >= best_length_ff);

   assign best_start_n  = take_run ? judge_start : best_start_ff;
   assign best_end_n    = take_run ? judge_end   : best_end_ff;
   assign best_length_n = take_run ? judge_len   : best_length_ff;

   // row-end result
   assign found   = best_length_n != '0;
   assign left    = found ? best_start_n : '0;
   assign right   = found ? best_end_n   : '0;
   assign mid_sum = {1'b0, left} + {1'b0, right};
   assign mvalid  = found || (prev_mid_valid_ff && !first);
   assign mid     = found ? mid_sum[COL_W:1] : (mvalid ? prev_mid_ff : '0);

   always_comb begin
      column_in         = column_ff;
      run_start_in      = run_start_ff;
      run_length_in     = run_length_ff;
      best_start_in     = best_start_ff;
      best_end_in       = best_end_ff;
      best_length_in    = best_length_ff;
      prev_left_in      = prev_left_ff;
      prev_right_in     = prev_right_ff;
      prev_found_in     = prev_found_ff;
      prev_mid_in       = prev_mid_ff;
      prev_mid_valid_in = prev_mid_valid_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in       = rsp_data_ff;
      if (advance) begin
         if (row_end) begin
            column_in              = '0;
            run_start_in           = '0;
            run_length_in          = '0;
            best_start_in          = '0;
            best_end_in            = '0;
            best_length_in         = '0;
            prev_left_in           = left;
            prev_right_in          = right;
            prev_found_in          = found;
            prev_mid_in            = mid;
            prev_mid_valid_in      = mvalid;
            rsp_valid_in           = 1'b1;
            rsp_data_in.left_edge  = left;
            rsp_data_in.right_edge = right;
            rsp_data_in.edge_found = found;
            rsp_data_in.mid_column = mid;
            rsp_data_in.mid_valid  = mvalid;
         end else begin
            column_in      = column_ff + COL_W'(1);
            run_start_in   = run_start_n;
            run_length_in  = run_length_n;
            best_start_in  = best_start_n;
            best_end_in    = best_end_n;
            best_length_in = best_length_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff         <= '0;
         run_start_ff      <= '0;
         run_length_ff     <= '0;
         best_start_ff     <= '0;
         best_end_ff       <= '0;
         best_length_ff    <= '0;
         prev_left_ff      <= '0;
         prev_right_ff     <= '0;
         prev_found_ff     <= 1'b0;
         prev_mid_ff       <= '0;
         prev_mid_valid_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         column_ff         <= column_in;
         run_start_ff      <= run_start_in;
         run_length_ff     <= run_length_in;
         best_start_ff     <= best_start_in;
         best_end_ff       <= best_end_in;
         best_length_ff    <= best_length_in;
         prev_left_ff      <= prev_left_in;
         prev_right_ff     <= prev_right_in;
         prev_found_ff     <= prev_found_in;
         prev_mid_ff       <= prev_mid_in;
         prev_mid_valid_ff <= prev_mid_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule

// ===== rtl/track_edge_row_scan.sv =====
// ----------------------------------------------------------------------------
// track_edge_row_scan: longest-run lane edge scan over a binary road mask
// Top level: row_width register, input register and scan core.
// ----------------------------------------------------------------------------
// Pixels enter one word per clock while not stalled, row by row from the
// bottom row upward; first_row is set on every pixel of the first scanned
// row. The block takes a pixel on every cycle that it is not stalled and
// emits one result word at the last pixel of each row, after that pixel
// passes the input register and then the result register. The pixel stream
// stalls only when a row-end pixel finds the previous result word untaken.
// row_width (0 acts as 1, values above the cap act as the cap) is to be
// written through csr_wr_en / csr_wr_data only while the block is idle;
// the block does not enforce this. No clearing pass after reset is needed.
module track_edge_row_scan import tersc_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [ROW_WIDTH_W-1:0] csr_wr_data,
   tersc_req_if.sink              req_if,
   tersc_rsp_if.source            rsp_if
);

   logic [ROW_WIDTH_W-1:0] row_width_ff, row_width_in;
   stage_type              stage;
   logic                   advance;

   // row_width register
   assign row_width_in = csr_wr_en ? csr_wr_data : row_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
      end else begin
         row_width_ff <= row_width_in;
      end
   end

   tersc_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (advance),
      .stage   (stage)
   );

   tersc_core #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .row_width (row_width_ff),
      .stage     (stage),
      .advance   (advance),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== rtl/tersc_checker.sv =====
// ----------------------------------------------------------------------------
// tersc_checker: port checks for the row-scan lane edge finder
// Watches the result channel and checks the edge words it carries.
// ----------------------------------------------------------------------------
module tersc_checker import tersc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   // a found segment never runs backwards
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.edge_found |->
         rsp_payload.left_edge <= rsp_payload.right_edge)
      else $error("left edge beyond right edge");

   // found segment gives its own midline inside the segment
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.edge_found |->
         rsp_payload.mid_valid &&
         rsp_payload.mid_column >= rsp_payload.left_edge &&
         rsp_payload.mid_column <= rsp_payload.right_edge)
      else $error("midline outside found segment");

   // no segment: edges and an invalid midline read zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.edge_found |->
         rsp_payload.left_edge == '0 && rsp_payload.right_edge == '0 &&
         (rsp_payload.mid_valid || rsp_payload.mid_column == '0))
      else $error("stale values in empty row result");

endmodule

bind track_edge_row_scan tersc_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

// ===== verif/row_scan_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_scan_checker: result predictor and scoreboard for the lane edge scan
// Watches the register port and both channels. Every pixel word taken by
// the block is run through a local model of the row scan. A row end queues
// the expected result word, and each result word taken is checked against
// the oldest one, field by field.
// ----------------------------------------------------------------------------
module row_scan_checker import tersc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [ROW_WIDTH_W-1:0] csr_wr_data,
   tersc_req_if                   req_mon,
   tersc_rsp_if                   rsp_mon,
   output int                     fail_count,
   output int                     waiting,
   output int                     rows_checked,
   output int                     rows_found
);

   // local copy of the register and of the scan state
   logic [ROW_WIDTH_W-1:0] row_width;
   logic [COL_W-1:0]       col;
   logic [COL_W-1:0]       run_start;
   logic [LEN_W-1:0]       run_len;
   logic [COL_W-1:0]       best_start;
   logic [COL_W-1:0]       best_end;
   logic [LEN_W-1:0]       best_len;
   logic [COL_W-1:0]       prev_left;
   logic [COL_W-1:0]       prev_right;
   logic                   prev_found;
   logic [COL_W-1:0]       prev_mid;
   logic                   prev_mid_valid;

   rsp_payload_type expected_rows[$];

   function automatic void clear_scan();
      col            = '0;
      run_start      = '0;
      run_len        = '0;
      best_start     = '0;
      best_end       = '0;
      best_len       = '0;
      prev_left      = '0;
      prev_right     = '0;
      prev_found     = 1'b0;
      prev_mid       = '0;
      prev_mid_valid = 1'b0;
   endfunction

   // last column of a row; zero acts as one, anything wide is capped
   function automatic logic [COL_W-1:0] last_column();
      logic [ROW_WIDTH_W-1:0] w;
      w = row_width;
      if (w == '0) w = ROW_WIDTH_W'(1);
      if (w > ROW_WIDTH_W'(WIDTH_CAP)) w = ROW_WIDTH_W'(WIDTH_CAP);
      return COL_W'(w - ROW_WIDTH_W'(1));
   endfunction

   // a finished run counts if it is on the first row or touches last row's pick
   function automatic void weigh_run(input logic [COL_W-1:0] run_end, input logic first);
      logic ok;
      if (run_len == 0) return;
      ok = first || (prev_found && !(prev_left > run_end || prev_right < run_start));
      if (ok && run_len >= best_len) begin
         best_len   = run_len;
         best_start = run_start;
         best_end   = run_end;
      end
   endfunction

   // advance the scan by one pixel; a row end queues its result word
   function automatic void scan_pixel(input logic white, input logic first);
      logic            at_end;
      logic [LEN_W-1:0] sum;
      rsp_payload_type row;
      at_end = col >= last_column();
      if (white) begin
         if (run_len == 0) begin
            run_start = col;
            run_len   = LEN_W'(1);
         end else if (run_len != {LEN_W{1'b1}}) begin
            run_len = run_len + 1'b1;
         end
         if (at_end) weigh_run(col, first);
      end else begin
         if (run_len != 0) weigh_run(col - 1'b1, first);
         run_len   = '0;
         run_start = '0;
      end
      if (!at_end) begin
         col = col + 1'b1;
         return;
      end

      row.edge_found = best_len != 0;
      if (row.edge_found) begin
         row.left_edge  = best_start;
         row.right_edge = best_end;
         sum            = {1'b0, best_start} + {1'b0, best_end};
         row.mid_column = sum[LEN_W-1:1];
         row.mid_valid  = 1'b1;
      end else begin
         row.left_edge  = '0;
         row.right_edge = '0;
         row.mid_valid  = prev_mid_valid && !first;
         row.mid_column = row.mid_valid ? prev_mid : '0;
      end
      expected_rows = {expected_rows, row};

      prev_left      = row.left_edge;
      prev_right     = row.right_edge;
      prev_found     = row.edge_found;
      prev_mid       = row.mid_column;
      prev_mid_valid = row.mid_valid;
      col        = '0;
      run_start  = '0;
      run_len    = '0;
      best_start = '0;
      best_end   = '0;
      best_len   = '0;
   endfunction

   function automatic void check_field(input string name, input logic [COL_W-1:0] want,
                                       input logic [COL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // sample at each edge: register writes, pixel words, result words
   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         row_width = ROW_WIDTH_RESET;
         clear_scan();
         expected_rows.delete();
      end else begin
         if (csr_wr_en) row_width = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            scan_pixel(req_mon.payload.pixel, req_mon.payload.first_row);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_rows.size() == 0) begin
               $error("result word with no row end pending: left %0d right %0d",
                      got.left_edge, got.right_edge);
               fail_count++;
            end else begin
               want = expected_rows.pop_front();
               check_field("left_edge", want.left_edge, got.left_edge);
               check_field("right_edge", want.right_edge, got.right_edge);
               check_field("edge_found", want.edge_found, got.edge_found);
               check_field("mid_column", want.mid_column, got.mid_column);
               check_field("mid_valid", want.mid_valid, got.mid_valid);
               rows_checked++;
               if (want.edge_found) rows_found++;
            end
         end
      end
      waiting <= expected_rows.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for the row-scan lane edge finder
// Drives pixel rows shaped like a drifting lane, with noise, blank and full
// rows, over many row widths including zero, one and the capped extremes.
// Both channels idle at random; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
   import tersc_pkg::*;

   localparam int RANDOM_PIXELS = 1000;
   localparam int QUIET_LIMIT   = 2000;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [ROW_WIDTH_W-1:0] csr_wr_data;
   logic                   calm;
   int                     fail_count;
   int                     waiting;
   int                     rows_checked;
   int                     rows_found;
   int                     pixels_sent;
   int                     widths_set;
   int                     quiet_cycles;
   int                     lane_lo;
   int                     lane_hi;

   tersc_req_if req_if ();
   tersc_rsp_if rsp_if ();

   track_edge_row_scan i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .rsp_if      (rsp_if)
   );

   row_scan_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .fail_count   (fail_count),
      .waiting      (waiting),
      .rows_checked (rows_checked),
      .rows_found   (rows_found)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: takes about three words in four, always during the calm stretch
   always @(posedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(99) >= 24);
   end

   // watchdog: too long without any word moving ends the run
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("track_edge_row_scan regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one pixel word, with random idle cycles ahead of it
   task automatic send_pixel(input logic white, input logic first);
      req_payload_type word;
      word.pixel     = white;
      word.first_row = first;
      while (!calm && $urandom_range(99) < 24) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= word;
      do @(posedge clock); while (!req_if.ready);
      pixels_sent++;
   endtask

   // bit i of the pattern goes to column i
   task automatic send_pattern(input logic [15:0] bits, input int n, input logic first);
      for (int c = 0; c < n; c++) send_pixel(bits[c], first);
   endtask

   // register write once every pending row has come out and the pipe is empty
   task automatic set_row_width(input logic [ROW_WIDTH_W-1:0] w);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (waiting != 0);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      widths_set++;
   endtask

   // one row: 0 lane with noise, 1 random noise, 2 blank, 3 all white
   task automatic send_row(input int w, input logic first, input int kind);
      logic white;
      logic flag;
      for (int c = 0; c < w; c++) begin
         case (kind)
            0: begin
               white = (c >= lane_lo) && (c <= lane_hi);
               if ($urandom_range(15) == 0) white = ~white;
            end
            1: white = 1'($urandom_range(1));
            2: white = 1'b0;
            default: white = 1'b1;
         endcase
         flag = first;
         if ($urandom_range(31) == 0) flag = ~flag;
         send_pixel(white, flag);
      end
      // let the lane wander a little
      lane_lo = lane_lo + $urandom_range(4) - 2;
      lane_hi = lane_hi + $urandom_range(4) - 2;
      if (lane_lo < 0) lane_lo = 0;
      if (lane_hi > w - 1) lane_hi = w - 1;
      if (lane_hi < lane_lo) lane_hi = lane_lo;
   endtask

   initial begin : stimulus
      int                     phase;
      int                     eff;
      int                     rows;
      int                     pick;
      int                     kind;
      logic                   fresh;
      logic [ROW_WIDTH_W-1:0] w;
      reset          = 1'b1;
      calm           = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      pixels_sent    = 0;
      widths_set     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // width zero acts as one: every pixel is a row; carry and no-previous cases
      set_row_width(0);
      send_pixel(1'b1, 1'b1);
      send_pixel(1'b0, 1'b0);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b0, 1'b1);

      // overlap with last row, ties going to the later run, mixed first_row flags
      set_row_width(4);
      send_pattern(16'b1011, 4, 1'b1);
      send_pattern(16'b1101, 4, 1'b0);
      send_pattern(16'b1001, 4, 1'b1);
      send_pixel(1'b0, 1'b0);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b0, 1'b1);
      send_pixel(1'b1, 1'b0);

      // narrowing the row part way through: the next pixel closes the row
      set_row_width(8);
      send_pattern(16'b10111, 5, 1'b0);
      set_row_width(3);
      send_pixel(1'b1, 1'b0);

      // random phases: lane sequences at many widths, two full-width ones
      phase = 0;
      while (pixels_sent < RANDOM_PIXELS + 26) begin
         calm = (pixels_sent >= 450) && (pixels_sent < 650);
         pick = $urandom_range(99);
         if (phase == 2)       w = {ROW_WIDTH_W{1'b1}};
         else if (phase == 5)  w = ROW_WIDTH_W'(WIDTH_CAP);
         else if (pick < 8)    w = '0;
         else if (pick < 16)   w = ROW_WIDTH_W'(1);
         else if (pick < 24)   w = ROW_WIDTH_W'(2);
         else if (pick < 27)   w = ROW_WIDTH_W'($urandom_range(257, 300));
         else                  w = ROW_WIDTH_W'($urandom_range(3, 24));
         set_row_width(w);
         eff  = (w == 0) ? 1 : ((w > WIDTH_CAP) ? WIDTH_CAP : w);
         rows = (eff > 24) ? $urandom_range(1, 2) : $urandom_range(2, 16);
         fresh = $urandom_range(9) != 0;
         lane_lo = $urandom_range(eff - 1);
         lane_hi = (eff > 24) ? eff - 1 : lane_lo + $urandom_range(eff - 1 - lane_lo);
         for (int r = 0; r < rows; r++) begin
            pick = $urandom_range(99);
            if (pick < 75)      kind = 0;
            else if (pick < 87) kind = 1;
            else if (pick < 94) kind = 2;
            else                kind = 3;
            send_row(eff, (r == 0 && fresh) || ($urandom_range(19) == 0), kind);
         end
         phase++;
      end
      calm = 1'b0;

      // drain: wait for every row result, then a few more cycles
      req_if.valid <= 1'b0;
      do @(posedge clock); while (waiting != 0);
      repeat (8) @(posedge clock);
      $display("Sent %0d pixel words under %0d row width settings.", pixels_sent, widths_set);
      $display("Checked %0d row results, %0d of them with a lane segment.",
               rows_checked, rows_found);
      if (fail_count == 0 && waiting == 0)
         $display("track_edge_row_scan regression: pass");
      else
         $display("track_edge_row_scan regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tersc_pkg.sv
rtl/tersc_if.sv
rtl/tersc_in_reg.sv
rtl/tersc_core.sv
rtl/track_edge_row_scan.sv
rtl/tersc_checker.sv
verif/row_scan_checker.sv
verif/testbench.sv
